### rtl/cau_pkg.sv
// Shared constants, types and helpers for the complex arithmetic unit.
// No dependencies; used by every module of the block.
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 32;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int QUO_W      = DATA_WIDTH + 1;
    localparam int CMP_W      = PROD_W + QUO_W + 1;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } smag_t;

    // one item in flight through the quotient stages
    typedef struct packed {
        logic [1:0]        op;
        logic              dz;
        logic              neg_re;
        logic              neg_im;
        logic [NUM_W-1:0]  rem_re;
        logic [NUM_W-1:0]  rem_im;
        logic [QUO_W-1:0]  q_re;
        logic [QUO_W-1:0]  q_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [PROD_W-1:0] den;
    } div_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  sat;
    } clamp_t;

    function automatic smag_t sm_add(input smag_t x, input smag_t y);
        smag_t r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        return r;
    endfunction

    function automatic clamp_t clamp(input logic neg, input logic [NUM_W-1:0] mag,
                                     input logic force_sat);
        clamp_t           r;
        logic [NUM_W-1:0] lim_neg;
        logic [NUM_W-1:0] negm;
        lim_neg = NUM_W'(1) << (DATA_WIDTH - 1);
        negm    = NUM_W'(0) - mag;
        r.sat   = 1'b0;
        if (neg) begin
            if (force_sat || (mag > lim_neg)) begin
                r.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
                r.sat = 1'b1;
            end else begin
                r.val = negm[DATA_WIDTH-1:0];
            end
        end else begin
            if (force_sat || (mag > (lim_neg - NUM_W'(1)))) begin
                r.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                r.sat = 1'b1;
            end else begin
                r.val = mag[DATA_WIDTH-1:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/cau_divider.sv
// Pipelined restoring divider: one quotient bit per stage, both parts at once.
// Depends on cau_pkg. Items other than divides pass through unchanged.
`default_nettype none

module cau_divider (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire cau_pkg::div_item_t  in_item,
    output logic                     out_valid,
    output cau_pkg::div_item_t       out_item
);

    logic               vld_reg  [0:cau_pkg::QUO_W];
    cau_pkg::div_item_t itm_reg  [0:cau_pkg::QUO_W];
    cau_pkg::div_item_t stg_next [0:cau_pkg::QUO_W];

    always_comb
    begin
        logic [cau_pkg::CMP_W-1:0] shd;
        logic [cau_pkg::CMP_W-1:0] sub_re;
        logic [cau_pkg::CMP_W-1:0] sub_im;
        // entry stage: flag quotients that cannot fit the quotient bits
        stg_next[0] = in_item;
        shd = cau_pkg::CMP_W'(in_item.den) << cau_pkg::QUO_W;
        stg_next[0].ovf_re = (in_item.op == cau_pkg::OP_DIV) &&
                             (cau_pkg::CMP_W'(in_item.rem_re) >= shd);
        stg_next[0].ovf_im = (in_item.op == cau_pkg::OP_DIV) &&
                             (cau_pkg::CMP_W'(in_item.rem_im) >= shd);
        for (int k = 1; k <= cau_pkg::QUO_W; k++) begin
            stg_next[k] = itm_reg[k-1];
            shd    = cau_pkg::CMP_W'(itm_reg[k-1].den) << (cau_pkg::QUO_W - k);
            sub_re = cau_pkg::CMP_W'(itm_reg[k-1].rem_re) - shd;
            sub_im = cau_pkg::CMP_W'(itm_reg[k-1].rem_im) - shd;
            if (itm_reg[k-1].op == cau_pkg::OP_DIV) begin
                if (cau_pkg::CMP_W'(itm_reg[k-1].rem_re) >= shd) begin
                    stg_next[k].rem_re = sub_re[cau_pkg::NUM_W-1:0];
                    stg_next[k].q_re[cau_pkg::QUO_W - k] = 1'b1;
                end
                if (cau_pkg::CMP_W'(itm_reg[k-1].rem_im) >= shd) begin
                    stg_next[k].rem_im = sub_im[cau_pkg::NUM_W-1:0];
                    stg_next[k].q_im[cau_pkg::QUO_W - k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= cau_pkg::QUO_W; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= cau_pkg::QUO_W; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int k = 0; k <= cau_pkg::QUO_W; k++) begin
                itm_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_valid = vld_reg[cau_pkg::QUO_W];
    assign out_item  = itm_reg[cau_pkg::QUO_W];

endmodule

`default_nettype wire

### rtl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on signed fixed-point parts.
// Depends on cau_pkg and cau_divider.
//
// One item is accepted per cycle while the pipe advances; each result passes
// through operand decode, product, combine, overflow check, one stage per
// quotient bit of the divider for DATA_WIDTH+1 bits and the output register,
// the same for every opcode, so results leave in order. The divider's bit
// stages set the depth. The whole pipe advances whenever the output register
// is empty or being taken; results saturate with status 1, a zero divisor
// gives zero parts with status 2.
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] first_re,
    input  wire logic [31:0] first_im,
    input  wire logic [31:0] second_re,
    input  wire logic [31:0] second_im,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result_re,
    output logic [31:0]      result_im,
    output logic [1:0]       status
);

    localparam int W = cau_pkg::DATA_WIDTH;
    localparam int P = cau_pkg::PROD_W;

    logic en;

    // stage A: sign and magnitude of the operands (ar, ai, br, bi)
    logic         a_vld_reg;
    logic [1:0]   a_op_reg;
    logic         a_neg_reg  [0:3];
    logic [W-1:0] a_mag_reg  [0:3];
    logic         a_neg_next [0:3];
    logic [W-1:0] a_mag_next [0:3];

    // stage B: products and add/subtract results
    logic              b_vld_reg;
    logic [1:0]        b_op_reg;
    cau_pkg::smag_t    b_prod_reg  [0:3];   // rr, ii, ri, ir
    cau_pkg::smag_t    b_prod_next [0:3];
    logic [P-1:0]      b_dr_reg, b_di_reg;
    cau_pkg::smag_t    b_as_re_reg, b_as_im_reg;
    cau_pkg::smag_t    b_as_re_next, b_as_im_next;

    // stage C: combined numerators and divisor
    logic               c_vld_reg;
    cau_pkg::div_item_t c_item_reg;
    cau_pkg::div_item_t c_item_next;

    logic               d_vld;
    cau_pkg::div_item_t d_item;

    logic               out_valid_reg;
    logic [31:0]        result_re_reg, result_im_reg;
    logic [1:0]         status_reg;
    logic [31:0]        result_re_next, result_im_next;
    logic [1:0]         status_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        logic [W-1:0] sx [0:3];
        sx[0] = first_re[W-1:0];
        sx[1] = first_im[W-1:0];
        sx[2] = second_re[W-1:0];
        sx[3] = second_im[W-1:0];
        for (int n = 0; n < 4; n++) begin
            a_neg_next[n] = sx[n][W-1];
            a_mag_next[n] = sx[n][W-1] ? (W'(0) - sx[n]) : sx[n];
        end
    end

    always_comb
    begin
        cau_pkg::smag_t x_re, x_im, y_re, y_im;
        logic           flip;
        flip = (a_op_reg == cau_pkg::OP_SUB);
        x_re = '{neg: a_neg_reg[0], mag: P'(a_mag_reg[0])};
        x_im = '{neg: a_neg_reg[1], mag: P'(a_mag_reg[1])};
        y_re = '{neg: a_neg_reg[2] ^ flip, mag: P'(a_mag_reg[2])};
        y_im = '{neg: a_neg_reg[3] ^ flip, mag: P'(a_mag_reg[3])};
        b_as_re_next = cau_pkg::sm_add(x_re, y_re);
        b_as_im_next = cau_pkg::sm_add(x_im, y_im);
        b_prod_next[0].neg = a_neg_reg[0] ^ a_neg_reg[2];
        b_prod_next[0].mag = P'(a_mag_reg[0]) * P'(a_mag_reg[2]);
        b_prod_next[1].neg = a_neg_reg[1] ^ a_neg_reg[3];
        b_prod_next[1].mag = P'(a_mag_reg[1]) * P'(a_mag_reg[3]);
        b_prod_next[2].neg = a_neg_reg[0] ^ a_neg_reg[3];
        b_prod_next[2].mag = P'(a_mag_reg[0]) * P'(a_mag_reg[3]);
        b_prod_next[3].neg = a_neg_reg[1] ^ a_neg_reg[2];
        b_prod_next[3].mag = P'(a_mag_reg[1]) * P'(a_mag_reg[2]);
    end

    always_comb
    begin
        cau_pkg::smag_t vr, vi, ii_n, ri_n;
        logic [P-1:0]   den;
        ii_n = b_prod_reg[1];
        ii_n.neg = !ii_n.neg;
        ri_n = b_prod_reg[2];
        ri_n.neg = !ri_n.neg;
        den = b_dr_reg + b_di_reg;
        c_item_next = '0;
        c_item_next.op  = b_op_reg;
        c_item_next.den = den;
        unique case (b_op_reg)
            cau_pkg::OP_MUL:
            begin
                vr = cau_pkg::sm_add(b_prod_reg[0], ii_n);
                vi = cau_pkg::sm_add(b_prod_reg[2], b_prod_reg[3]);
                c_item_next.rem_re = cau_pkg::NUM_W'(vr.mag >> cau_pkg::FRAC_BITS);
                c_item_next.rem_im = cau_pkg::NUM_W'(vi.mag >> cau_pkg::FRAC_BITS);
            end
            cau_pkg::OP_DIV:
            begin
                vr = cau_pkg::sm_add(b_prod_reg[0], b_prod_reg[1]);
                vi = cau_pkg::sm_add(b_prod_reg[3], ri_n);
                c_item_next.rem_re = cau_pkg::NUM_W'(vr.mag) << cau_pkg::FRAC_BITS;
                c_item_next.rem_im = cau_pkg::NUM_W'(vi.mag) << cau_pkg::FRAC_BITS;
                c_item_next.dz     = (den == '0);
            end
            default:
            begin
                vr = b_as_re_reg;
                vi = b_as_im_reg;
                c_item_next.rem_re = cau_pkg::NUM_W'(vr.mag);
                c_item_next.rem_im = cau_pkg::NUM_W'(vi.mag);
            end
        endcase
        c_item_next.neg_re = vr.neg;
        c_item_next.neg_im = vi.neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            out_valid_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a_op_reg    <= opcode;
            b_op_reg    <= a_op_reg;
            for (int n = 0; n < 4; n++) begin
                a_neg_reg[n]  <= a_neg_next[n];
                a_mag_reg[n]  <= a_mag_next[n];
                b_prod_reg[n] <= b_prod_next[n];
            end
            b_dr_reg      <= P'(a_mag_reg[2]) * P'(a_mag_reg[2]);
            b_di_reg      <= P'(a_mag_reg[3]) * P'(a_mag_reg[3]);
            b_as_re_reg   <= b_as_re_next;
            b_as_im_reg   <= b_as_im_next;
            c_item_reg    <= c_item_next;
            result_re_reg <= result_re_next;
            result_im_reg <= result_im_next;
            status_reg    <= status_next;
        end
    end

    cau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_vld_reg),
        .in_item   (c_item_reg),
        .out_valid (d_vld),
        .out_item  (d_item)
    );

    always_comb
    begin
        cau_pkg::clamp_t cr, ci;
        if (d_item.op == cau_pkg::OP_DIV) begin
            cr = cau_pkg::clamp(d_item.neg_re, cau_pkg::NUM_W'(d_item.q_re), d_item.ovf_re);
            ci = cau_pkg::clamp(d_item.neg_im, cau_pkg::NUM_W'(d_item.q_im), d_item.ovf_im);
        end else begin
            cr = cau_pkg::clamp(d_item.neg_re, d_item.rem_re, 1'b0);
            ci = cau_pkg::clamp(d_item.neg_im, d_item.rem_im, 1'b0);
        end
        if ((d_item.op == cau_pkg::OP_DIV) && d_item.dz) begin
            result_re_next = '0;
            result_im_next = '0;
            status_next    = cau_pkg::ST_DIVZ;
        end else begin
            result_re_next = 32'($signed(cr.val));
            result_im_next = 32'($signed(ci.val));
            status_next    = (cr.sat || ci.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_re = result_re_reg;
    assign result_im = result_im_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

### rtl/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
`default_nettype none

module cau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  opcode,
    input wire logic [31:0] first_re,
    input wire logic [31:0] first_im,
    input wire logic [31:0] second_re,
    input wire logic [31:0] second_im,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] result_re,
    input wire logic [31:0] result_im,
    input wire logic [1:0]  status
);

    localparam logic [31:0] SAT_POS =
        32'((64'd1 << (cau_pkg::DATA_WIDTH - 1)) - 64'd1);
    localparam logic [31:0] SAT_NEG = ~SAT_POS;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_re) &&
        $stable(result_im) && $stable(status))
        else $error("result changed while stalled");

    // an empty output stage never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_divz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cau_pkg::ST_DIVZ) |-> (result_re == 32'd0) &&
        (result_im == 32'd0))
        else $error("divide by zero with nonzero parts");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == cau_pkg::ST_OK) || (status == cau_pkg::ST_SAT) ||
        (status == cau_pkg::ST_DIVZ))
        else $error("undefined status code");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cau_pkg::ST_SAT) |-> (result_re == SAT_POS) ||
        (result_re == SAT_NEG) || (result_im == SAT_POS) || (result_im == SAT_NEG))
        else $error("saturated status without a part at its limit");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

`default_nettype wire

### test/tb_complex_arithmetic_unit.sv
// Self-checking testbench for complex_arithmetic_unit: random and directed items,
// bursty sender, stalling receiver. Depends on cau_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] ar, ai, br, bi;
    } operands_t;

    typedef struct {
        logic [31:0] re, im;
        logic [1:0]  st;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] first_re, first_im, second_re, second_im;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_re, result_im;
    logic [1:0]  status;

    operands_t pending_q[$];
    answer_t   answers_q[$];
    int        errors = 0;
    int        cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    bit        long_hold_req = 0;
    bit        pause_send = 0;

    complex_arithmetic_unit dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // signed magnitude helpers at 128 bits
    function automatic logic [127:0] absv(input logic signed [127:0] x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic [31:0] saturate(input logic signed [127:0] v, inout bit sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1;
            return 32'h7fff_ffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // truncating divide of (n << FRAC_BITS) by den, magnitude capped at 2^64-1
    function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] n,
                                                        input logic [127:0] den);
        logic [127:0] q;
        q = (absv(n) << cau_pkg::FRAC_BITS) / den;
        if (q > 128'hffff_ffff_ffff_ffff)
            q = 128'hffff_ffff_ffff_ffff;
        return n < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic answer_t complex_result(input operands_t o);
        answer_t r;
        logic signed [127:0] ar, ai, br, bi, vr, vi;
        logic [127:0] den;
        bit sat;
        ar = $signed(o.ar);
        ai = $signed(o.ai);
        br = $signed(o.br);
        bi = $signed(o.bi);
        sat = 0;
        r.st = cau_pkg::ST_OK;
        case (o.op)
            cau_pkg::OP_ADD:
            begin
                vr = ar + br;
                vi = ai + bi;
            end
            cau_pkg::OP_SUB:
            begin
                vr = ar - br;
                vi = ai - bi;
            end
            cau_pkg::OP_MUL:
            begin
                vr = ar * br - ai * bi;
                vi = ar * bi + ai * br;
                vr = vr < 0 ? -$signed(absv(vr) >> cau_pkg::FRAC_BITS)
                            : (vr >>> cau_pkg::FRAC_BITS);
                vi = vi < 0 ? -$signed(absv(vi) >> cau_pkg::FRAC_BITS)
                            : (vi >>> cau_pkg::FRAC_BITS);
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.re = 0;
                    r.im = 0;
                    r.st = cau_pkg::ST_DIVZ;
                    return r;
                end
                vr = scaled_quot(ar * br + ai * bi, den);
                vi = scaled_quot(ai * br - ar * bi, den);
            end
        endcase
        r.re = saturate(vr, sat);
        r.im = saturate(vi, sat);
        if (sat)
            r.st = cau_pkg::ST_SAT;
        return r;
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            4, 5: return $signed(16'($urandom)) <<< $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input logic [1:0] op, input logic [31:0] ar, ai, br, bi);
        operands_t o;
        o.op = op;
        o.ar = ar;
        o.ai = ai;
        o.br = br;
        o.bi = bi;
        pending_q.push_back(o);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                answers_q.push_back(complex_result(pending_q.pop_front()));
                if (gap_left == 0 && burst_left > 0)
                    burst_left <= burst_left - 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pause_send || pending_q.size() == 0)
                    in_valid <= 0;
                else if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 0;
                end
                else if (burst_left == 0 && $urandom_range(0, 3) == 0)
                begin
                    gap_left <= $urandom_range(1, 12);
                    burst_left <= $urandom_range(1, 30);
                    in_valid <= 0;
                end
                else
                begin
                    in_valid <= 1;
                    opcode <= pending_q[0].op;
                    first_re <= pending_q[0].ar;
                    first_im <= pending_q[0].ai;
                    second_re <= pending_q[0].br;
                    second_im <= pending_q[0].bi;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req && hold_left == 0)
            begin
                hold_left <= 300;
                out_ready <= 0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= (hold_left == 1);
            end
            else
                out_ready <= (cycles % 29 < 20) ? ($urandom_range(0, 4) != 0) : 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_q.size() == 0)
            begin
                $display("%0t: unexpected result re=%h im=%h st=%0d", $time,
                         result_re, result_im, status);
                errors++;
            end
            else
            begin
                e = answers_q.pop_front();
                if (result_re !== e.re || result_im !== e.im || status !== e.st)
                begin
                    $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                             $time, e.re, e.im, e.st, result_re, result_im, status);
                    errors++;
                end
            end
        end
        if (cycles > 400000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] extremes[5];
        extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000, 32'hffff_ffff};
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        opcode = cau_pkg::OP_ADD;
        first_re = 0;
        first_im = 0;
        second_re = 0;
        second_im = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed: extremes per operation, divide by zero, saturation
        for (int op = 0; op < 4; op++)
            for (int k = 0; k < 5; k++)
                add_item(op[1:0], extremes[k], extremes[4-k], extremes[(k+2)%5], extremes[k]);
        add_item(cau_pkg::OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0);
        add_item(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h0);
        add_item(cau_pkg::OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
        add_item(cau_pkg::OP_DIV, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
        wait (pending_q.size() == 0 && answers_q.size() == 0);

        // long receiver hold while the sender keeps offering
        for (int i = 0; i < 200; i++)
            add_item(2'($urandom), rand_part(), rand_part(), rand_part(), rand_part());
        long_hold_req = 1;
        wait (hold_left != 0);
        long_hold_req = 0;
        wait (pending_q.size() == 0);

        for (int i = 0; i < 1500; i++)
        begin
            add_item(2'($urandom), rand_part(), rand_part(), rand_part(), rand_part());
            if (i == 700)
            begin
                wait (pending_q.size() == 0);
                pause_send = 1;
                wait (answers_q.size() == 0);
                pause_send = 0;
            end
        end
        wait (pending_q.size() == 0 && !in_valid);
        wait (answers_q.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
